/* sv/isrt_pkg.sv */
// Shared types for the insertion sort engine.
`timescale 1ns / 1ps

package isrt_pkg;

    // Width of one sorted element.
    localparam int unsigned DATA_W = 32;

    // Engine mode: loading a set, or draining the sorted run.
    typedef enum logic [0:0] {
        S_LOAD  = 1'b0,
        S_DRAIN = 1'b1
    } t_state;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic load;   // insert the broadcast value this cycle
        logic shift;  // move every element one cell toward the output
    } t_cell_ctl;

endpackage

/* sv/insertion_sort_engine_core.sv */
// Top level of the insertion sort engine: control and the chain of cells.
//
// Usage: signed values arrive on the input channel (i_valid / o_stall), one
// beat per element; i_last_in marks the final element of a set. Each element
// is inserted into a chain of CAPACITY cells in the cycle it is accepted, so
// the load phase takes one element per cycle. Elements beyond CAPACITY are
// discarded and the run is flagged with o_dropped.
// After the beat carrying i_last_in, the sorted run leaves on the output
// channel (o_valid / i_stall), smallest first, one beat per cycle while
// i_stall is low, with o_last_out on the largest element. The first result
// appears the cycle after the last input beat. The drain is a left shift
// along the chain.
// While the run drains, o_stall is high and no new element is taken.
// When the receiver raises i_stall, the chain holds and the result stays.
// Synchronous active-low reset empties the chain and clears the overflow flag.
`timescale 1ns / 1ps

module insertion_sort_engine_core
    import isrt_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_last_in,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_last_out,
    output logic                     o_dropped
);

    t_state    r_state;
    t_state    n_state;
    t_cell_ctl w_ctl;
    logic      r_ovf;
    logic      n_ovf;
    logic      r_dropped;
    logic      n_dropped;
    logic      w_in_acc;
    logic      w_out_acc;
    logic      w_full;

    logic signed [DATA_W-1:0] w_value   [CAPACITY];
    logic                     w_occ     [CAPACITY];
    logic                     w_greater [CAPACITY];

    // Chain of cells; cell 0 is the head and feeds the output.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_pv;
        logic                     w_po;
        logic                     w_pg;
        logic signed [DATA_W-1:0] w_nv;
        logic                     w_no;

        if (g == 0) begin : g_head
            assign w_pv = i_value;
            assign w_po = 1'b1;
            assign w_pg = 1'b0;
        end else begin : g_body
            assign w_pv = w_value[g-1];
            assign w_po = w_occ[g-1];
            assign w_pg = w_greater[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_nv = w_value[g];
            assign w_no = 1'b0;
        end else begin : g_mid
            assign w_nv = w_value[g+1];
            assign w_no = w_occ[g+1];
        end

        isrt_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ctl),
            .i_new_value    (i_value),
            .i_prev_value   (w_pv),
            .i_prev_occ     (w_po),
            .i_prev_greater (w_pg),
            .i_next_value   (w_nv),
            .i_next_occ     (w_no),
            .o_value        (w_value[g]),
            .o_occ          (w_occ[g]),
            .o_greater      (w_greater[g])
        );
    end

    assign w_full    = w_occ[CAPACITY-1];
    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;

    // Next state, chain control and overflow tracking.
    always_comb begin
        n_state   = r_state;
        n_ovf     = r_ovf;
        n_dropped = r_dropped;
        w_ctl     = '0;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    w_ctl.load = !w_full;
                    if (i_last_in) begin
                        n_dropped = r_ovf || w_full;
                        n_ovf     = 1'b0;
                        n_state   = S_DRAIN;
                    end else if (w_full) begin
                        n_ovf = 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                if (w_out_acc) begin
                    w_ctl.shift = 1'b1;
                    if (o_last_out) begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_ovf     <= 1'b0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ovf     <= n_ovf;
            r_dropped <= n_dropped;
        end
    end

    // Results come straight from the head cell of the chain.
    assign o_stall        = (r_state == S_DRAIN);
    assign o_valid        = (r_state == S_DRAIN);
    assign o_sorted_value = w_value[0];
    assign o_last_out     = !w_occ[1];
    assign o_dropped      = r_dropped;

endmodule

/* sv/isrt_cell.sv */
// One cell of the sorting chain: holds one element and its occupied flag.
`timescale 1ns / 1ps

module isrt_cell
    import isrt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctl                i_ctl,
    input  logic signed [DATA_W-1:0] i_new_value,
    input  logic signed [DATA_W-1:0] i_prev_value,
    input  logic                     i_prev_occ,
    input  logic                     i_prev_greater,
    input  logic signed [DATA_W-1:0] i_next_value,
    input  logic                     i_next_occ,
    output logic signed [DATA_W-1:0] o_value,
    output logic                     o_occ,
    output logic                     o_greater
);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;
    logic                     r_occ;
    logic                     n_occ;
    logic                     w_take;

    // Strictly greater elements move up, so equal values keep arrival order.
    assign o_greater = r_occ && (r_value > i_new_value);

    // The cell changes on insert when it moves up or is the first free cell.
    assign w_take = o_greater || (!r_occ && i_prev_occ);

    always_comb begin
        n_value = r_value;
        n_occ   = r_occ;
        if (i_ctl.shift) begin
            n_value = i_next_value;
            n_occ   = i_next_occ;
        end else if (i_ctl.load && w_take) begin
            n_value = i_prev_greater ? i_prev_value : i_new_value;
            n_occ   = 1'b1;
        end
    end

    // Occupied flag is control state; the element itself needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_occ   = r_occ;

endmodule

/* verif/insertion_sort_engine_core_tb.sv */
// Self-checking testbench for the insertion sort engine core.
`timescale 1ns / 1ps

module insertion_sort_engine_core_tb;
    import isrt_pkg::*;

    localparam int unsigned CAPACITY   = 64;
    localparam int          RAND_ITEMS = 430;
    localparam int          IDLE_LIMIT = 2000;
    localparam int          HOLD_LEN   = 300;
    localparam int          DRAIN_TAIL = 20;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // Value classes for the random sets.
    typedef enum int {
        MIX_FULL,
        MIX_DUPS,
        MIX_EDGES
    } t_value_mix;

    // One sorted element as it should leave the block.
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last_out;
        logic                     dropped;
    } t_sort_result;

    // One directed input beat; a typed row is a one-element set whose result
    // is simply the value itself.
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        bit                       typed;
    } t_stim_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     i_last_in = 1'b0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [DATA_W-1:0] o_sorted_value;
    logic                     o_last_out;
    logic                     o_dropped;

    // Shadow of the engine: the set loaded so far, kept in ascending order.
    logic signed [DATA_W-1:0] sorted_elements[$];
    bit                       set_overflowed;
    t_sort_result             pending_results[$];

    int  mismatch_count = 0;
    int  results_seen   = 0;
    int  idle_cycles    = 0;
    bit  sender_calm    = 1'b0;
    bit  receiver_calm  = 1'b0;

    t_stim_row directed_rows [0:21] = '{
        '{VAL_MIN,         1'b1, 1'b1},
        '{VAL_MAX,         1'b1, 1'b1},
        '{32'sd0,          1'b1, 1'b1},
        '{-32'sd1,         1'b1, 1'b1},
        '{32'sh5555_5555,  1'b1, 1'b1},
        '{32'shAAAA_AAAA,  1'b1, 1'b1},
        '{32'sd7,          1'b0, 1'b0},
        '{-32'sd7,         1'b0, 1'b0},
        '{VAL_MAX,         1'b0, 1'b0},
        '{VAL_MIN,         1'b0, 1'b0},
        '{32'sd0,          1'b1, 1'b0},
        '{32'sd3,          1'b0, 1'b0},
        '{32'sd3,          1'b0, 1'b0},
        '{-32'sd2,         1'b0, 1'b0},
        '{32'sd3,          1'b1, 1'b0},
        '{32'sd40,         1'b0, 1'b0},
        '{32'sd30,         1'b0, 1'b0},
        '{32'sd20,         1'b0, 1'b0},
        '{32'sd10,         1'b1, 1'b0},
        '{32'sd1,          1'b0, 1'b0},
        '{32'sd2,          1'b0, 1'b0},
        '{32'sd3,          1'b1, 1'b0}
    };

    insertion_sort_engine_core #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value       (i_value),
        .i_last_in     (i_last_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sorted_value(o_sorted_value),
        .o_last_out    (o_last_out),
        .o_dropped     (o_dropped)
    );

    always #2 i_clk = ~i_clk;

    // Stable insertion of one accepted element; on the last element of a set
    // the whole run is queued when asked for, then the set is cleared.
    function automatic void insert_sorted(input logic signed [DATA_W-1:0] v,
                                          input logic last, input bit queue_run);
        int           pos;
        t_sort_result res;
        if (sorted_elements.size() < CAPACITY) begin
            pos = sorted_elements.size();
            while (pos > 0 && sorted_elements[pos-1] > v) pos--;
            sorted_elements.insert(pos, v);
        end else begin
            set_overflowed = 1'b1;
        end
        if (last) begin
            if (queue_run) begin
                foreach (sorted_elements[k]) begin
                    res.value    = sorted_elements[k];
                    res.last_out = (k == sorted_elements.size() - 1);
                    res.dropped  = set_overflowed;
                    pending_results.insert(pending_results.size(), res);
                end
            end
            sorted_elements.delete();
            set_overflowed = 1'b0;
        end
    endfunction

    // Mostly back-to-back, with short and occasional long gaps.
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value(input t_value_mix mix);
        unique case (mix)
            MIX_DUPS:  return $signed($urandom_range(0, 8)) - 4;
            MIX_EDGES: begin
                unique case ($urandom_range(0, 3))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default:   return $signed($urandom);
        endcase
    endfunction

    // Offers one beat, waits for it to be taken and records the expectation.
    task automatic drive_beat(input logic signed [DATA_W-1:0] v, input logic last,
                              input bit typed);
        int           gap;
        t_sort_result res;
        gap = pick_gap(sender_calm);
        if (gap > 0) begin
            i_valid   <= 1'b0;
            i_value   <= $urandom;
            i_last_in <= $urandom_range(0, 1);
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_value   <= v;
        i_last_in <= last;
        do @(posedge i_clk); while (o_stall);
        insert_sorted(v, last, !typed);
        if (typed) begin
            res.value    = v;
            res.last_out = 1'b1;
            res.dropped  = 1'b0;
            pending_results.insert(pending_results.size(), res);
        end
        @(negedge i_clk);
    endtask

    // Receiver: random stalls, plus one long hold once 40 results have been seen.
    initial begin : receiver_stalls
        int  stall_left;
        int  cyc;
        bit  hold_done;
        int  r;
        stall_left = 0;
        cyc        = 0;
        hold_done  = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 150 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
            if (!hold_done && results_seen >= 40) begin
                hold_done  = 1'b1;
                stall_left = HOLD_LEN;
            end else if (stall_left == 0 && !receiver_calm) begin
                r = $urandom_range(0, 99);
                if (r >= 60) stall_left = (r < 92) ? $urandom_range(1, 3)
                                                   : $urandom_range(8, 40);
            end
            i_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
        end
    end

    // Compare each accepted output beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_sort_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result value=%0d last=%b dropped=%b", $time,
                         o_sorted_value, o_last_out, o_dropped);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_sorted_value !== want.value) begin
                    $display("%0t: sorted_value expected %0d got %0d", $time,
                             want.value, o_sorted_value);
                    mismatch_count++;
                end
                if (o_last_out !== want.last_out) begin
                    $display("%0t: last_out expected %b got %b", $time,
                             want.last_out, o_last_out);
                    mismatch_count++;
                end
                if (o_dropped !== want.dropped) begin
                    $display("%0t: dropped expected %b got %b", $time,
                             want.dropped, o_dropped);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any beat on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Reset, directed table, random sets, then the drain at the end.
    initial begin : stimulus
        int         sent;
        int         set_len;
        int         set_idx;
        int         r;
        t_value_mix mix;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i])
            drive_beat(directed_rows[i].value, directed_rows[i].last,
                       directed_rows[i].typed);

        // The first two sets fill the store exactly and then overflow it.
        sent    = 0;
        set_idx = 0;
        while (sent < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (set_idx == 0) set_len = CAPACITY;
            else if (set_idx == 1) set_len = CAPACITY + 3;
            else if (r < 70) set_len = $urandom_range(1, 10);
            else if (r < 90) set_len = $urandom_range(11, 40);
            else set_len = $urandom_range(CAPACITY - 4, CAPACITY + 6);
            r           = $urandom_range(0, 99);
            mix         = (r < 60) ? MIX_FULL : (r < 90) ? MIX_DUPS : MIX_EDGES;
            sender_calm = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < set_len; k++)
                drive_beat(pick_value(mix), (k == set_len - 1), 1'b0);
            sent += set_len;
            set_idx++;
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/isrt_pkg.sv
sv/isrt_cell.sv
sv/insertion_sort_engine_core.sv
verif/insertion_sort_engine_core_tb.sv
